/* hdl/sshkp_pkg.sv */
package sshkp_pkg;

  localparam int unsigned NameLen  = 11;
  localparam int unsigned BlobLen  = 51;
  localparam int unsigned KeyLen   = 32;
  localparam int unsigned KeyAt    = 19;
  localparam int unsigned CountSat = 97;

  localparam int unsigned KeyIdxW = $clog2(KeyLen);

  localparam logic StatusAccept = 1'b0;
  localparam logic StatusReject = 1'b1;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [7:0]         key_byte;
    logic [KeyIdxW-1:0] key_index;
    logic               last_out;
  } out_item_t;

  // one key byte write into the double-buffered key store
  typedef struct packed {
    logic               en;
    logic               bank;
    logic [KeyIdxW-1:0] idx;
    logic [7:0]         data;
  } key_wr_t;

  // finished line handed from parser to result sequencer
  typedef struct packed {
    logic valid;
    logic reject;
    logic bank;
  } job_t;

endpackage

/* hdl/sshkp_parser.sv */
module sshkp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  sshkp_pkg::in_item_t in_data_i,
  output sshkp_pkg::key_wr_t  key_wr_o,
  output sshkp_pkg::job_t     job_o
);
  import sshkp_pkg::*;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChPad   = 8'h3d;
  localparam logic [5:0] DigPlus  = 6'd62;
  localparam logic [5:0] DigSlash = 6'd63;

  typedef enum logic [2:0] {
    PhLead,
    PhName,
    PhSep,
    PhGap,
    PhField,
    PhTail
  } phase_e;

  function automatic logic [7:0] name_char(input logic [3:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:    ch = 8'h73;
      4'd1:    ch = 8'h73;
      4'd2:    ch = 8'h68;
      4'd3:    ch = 8'h2d;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h64;
      4'd6:    ch = 8'h32;
      4'd7:    ch = 8'h35;
      4'd8:    ch = 8'h35;
      4'd9:    ch = 8'h31;
      4'd10:   ch = 8'h39;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // {valid, value}
  function automatic logic [6:0] b64_digit(input logic [7:0] c);
    logic [7:0] t;
    logic [6:0] r;
    t = 8'h00;
    r = 7'h00;
    if (c >= 8'h41 && c <= 8'h5a) begin
      t = c - 8'h41;
      r = {1'b1, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      t = c - 8'h61 + 8'd26;
      r = {1'b1, t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
      r = {1'b1, t[5:0]};
    end else if (c == 8'h2b) begin
      r = {1'b1, DigPlus};
    end else if (c == 8'h2f) begin
      r = {1'b1, DigSlash};
    end
    return r;
  endfunction

  phase_e      phase_q, phase_d;
  logic [3:0]  match_q, match_d;
  logic [12:0] acc_q, acc_d;
  logic [2:0]  bits_q, bits_d;
  logic [2:0]  enc_q, enc_d;
  logic [1:0]  pad_q, pad_d;
  logic [6:0]  dec_q, dec_d;
  logic        rej_q, rej_d;
  logic        bank_q, bank_d;

  logic [7:0]  ch;
  logic        blank, is_cr, do_name, do_field, chk, ok;
  logic [6:0]  dig, d_off;
  logic [12:0] acc_sh;
  logic [3:0]  bits_sum;
  logic [2:0]  bits_new;
  logic [7:0]  dbyte, want;

  assign ch    = in_data_i.char_in;
  assign blank = (ch == ChSpace) || (ch == ChTab);
  assign is_cr = (ch == ChCr);
  assign dig   = b64_digit(ch);

  always_comb begin
    phase_d  = phase_q;
    match_d  = match_q;
    acc_d    = acc_q;
    bits_d   = bits_q;
    enc_d    = enc_q;
    pad_d    = pad_q;
    dec_d    = dec_q;
    rej_d    = rej_q;
    bank_d   = bank_q;
    do_name  = 1'b0;
    do_field = 1'b0;
    chk      = 1'b0;
    ok       = 1'b0;
    want     = 8'h00;
    dbyte    = 8'h00;
    acc_sh   = {acc_q[6:0], dig[5:0]};
    bits_sum = {1'b0, bits_q} + 4'd6;
    bits_new = 3'(bits_sum - 4'd8);
    d_off    = dec_q - 7'd4;
    key_wr_o = '0;
    job_o    = '0;

    if (in_valid_i && in_ready_i) begin
      if (!rej_q) begin
        unique case (phase_q)
          PhLead:  do_name = !blank;
          PhName:  do_name = 1'b1;
          PhSep: begin
            if (blank) phase_d = PhGap;
            else rej_d = 1'b1;
          end
          PhGap: begin
            if (is_cr) begin
              rej_d = 1'b1;
            end else if (!blank) begin
              phase_d  = PhField;
              do_field = 1'b1;
            end
          end
          PhField: begin
            if (blank || is_cr) phase_d = PhTail;
            else do_field = 1'b1;
          end
          default: ;
        endcase

        if (do_name) begin
          if (match_q >= 4'(NameLen) || ch != name_char(match_q)) begin
            rej_d = 1'b1;
          end else begin
            match_d = match_q + 4'd1;
            phase_d = (match_q == 4'(NameLen - 1)) ? PhSep : PhName;
          end
        end

        if (do_field) begin
          enc_d = {1'b1, enc_q[1:0] + 2'd1};
          if (ch == ChPad) begin
            if (pad_q >= 2'd2) rej_d = 1'b1;
            else pad_d = pad_q + 2'd1;
          end else if (pad_q != 2'd0 || !dig[6]) begin
            rej_d = 1'b1;
          end else if (bits_sum >= 4'd8) begin
            // a whole byte is ready: take it from above the leftover bits
            dbyte  = 8'(acc_sh >> bits_new);
            acc_d  = acc_sh & ((13'd1 << bits_new) - 13'd1);
            bits_d = bits_new;
            if (dec_q < 7'd3) begin
              chk = 1'b1;
            end else if (dec_q == 7'd3) begin
              chk  = 1'b1;
              want = 8'(NameLen);
            end else if (dec_q < 7'(4 + NameLen)) begin
              chk  = 1'b1;
              want = name_char(d_off[3:0]);
            end else if (dec_q < 7'(KeyAt - 1)) begin
              chk = 1'b1;
            end else if (dec_q == 7'(KeyAt - 1)) begin
              chk  = 1'b1;
              want = 8'(KeyLen);
            end else if (dec_q < 7'(BlobLen)) begin
              key_wr_o.en   = 1'b1;
              key_wr_o.bank = bank_q;
              key_wr_o.idx  = KeyIdxW'(dec_q - 7'(KeyAt));
              key_wr_o.data = dbyte;
            end
            if (chk && want != dbyte) rej_d = 1'b1;
            if (dec_q < 7'(CountSat)) dec_d = dec_q + 7'd1;
          end else begin
            acc_d  = acc_sh;
            bits_d = bits_sum[2:0];
          end
        end
      end

      if (in_data_i.line_end) begin
        ok = !rej_d && (phase_d == PhField || phase_d == PhTail) &&
             enc_d == 3'b100 && dec_d == 7'(BlobLen);
        job_o.valid  = 1'b1;
        job_o.reject = !ok;
        job_o.bank   = bank_q;
        if (ok) bank_d = !bank_q;
        phase_d = PhLead;
        match_d = '0;
        acc_d   = '0;
        bits_d  = '0;
        enc_d   = '0;
        pad_d   = '0;
        dec_d   = '0;
        rej_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLead;
      match_q <= '0;
      acc_q   <= '0;
      bits_q  <= '0;
      enc_q   <= '0;
      pad_q   <= '0;
      dec_q   <= '0;
      rej_q   <= 1'b0;
      bank_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      match_q <= match_d;
      acc_q   <= acc_d;
      bits_q  <= bits_d;
      enc_q   <= enc_d;
      pad_q   <= pad_d;
      dec_q   <= dec_d;
      rej_q   <= rej_d;
      bank_q  <= bank_d;
    end
  end

endmodule

/* hdl/sshkp_emit.sv */
module sshkp_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sshkp_pkg::key_wr_t   key_wr_i,
  input  sshkp_pkg::job_t      job_i,
  output logic                job_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sshkp_pkg::out_item_t out_data_o
);
  import sshkp_pkg::*;

  // two banks of key bytes, one being filled while the other is sent
  logic [7:0] key_mem [2*KeyLen];
  logic [7:0] rdata_q;

  logic               act_valid_q, act_reject_q, act_bank_q;
  logic [KeyIdxW-1:0] act_idx_q;
  logic               pend_valid_q, pend_reject_q, pend_bank_q;

  logic               s1_valid_q, s1_reject_q, s1_last_q;
  logic [KeyIdxW-1:0] s1_idx_q;

  logic      out_valid_q;
  out_item_t out_q;

  logic act_last, s1_adv, issue, act_load;

  assign act_last = act_reject_q || (act_idx_q == KeyIdxW'(KeyLen - 1));
  assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign issue    = act_valid_q && (!s1_valid_q || s1_adv);
  assign act_load = !act_valid_q || (issue && act_last);

  assign job_ready_o = !pend_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (key_wr_i.en) key_mem[{key_wr_i.bank, key_wr_i.idx}] <= key_wr_i.data;
    if (issue) rdata_q <= key_mem[{act_bank_q, act_idx_q}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_valid_q   <= 1'b0;
      act_reject_q  <= 1'b0;
      act_bank_q    <= 1'b0;
      act_idx_q     <= '0;
      pend_valid_q  <= 1'b0;
      pend_reject_q <= 1'b0;
      pend_bank_q   <= 1'b0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (act_load) begin
        act_idx_q <= '0;
        if (pend_valid_q) begin
          act_valid_q  <= 1'b1;
          act_reject_q <= pend_reject_q;
          act_bank_q   <= pend_bank_q;
          pend_valid_q <= 1'b0;
        end else begin
          act_valid_q  <= job_i.valid;
          act_reject_q <= job_i.reject;
          act_bank_q   <= job_i.bank;
        end
      end else begin
        if (issue) act_idx_q <= act_idx_q + KeyIdxW'(1);
        if (job_i.valid) begin
          pend_valid_q  <= 1'b1;
          pend_reject_q <= job_i.reject;
          pend_bank_q   <= job_i.bank;
        end
      end

      if (issue) s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;

      if (s1_adv) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_reject_q <= act_reject_q;
      s1_idx_q    <= act_idx_q;
      s1_last_q   <= act_last;
    end
    if (s1_adv) begin
      out_q.status    <= s1_reject_q ? StatusReject : StatusAccept;
      out_q.key_byte  <= s1_reject_q ? 8'h00 : rdata_q;
      out_q.key_index <= s1_reject_q ? '0 : s1_idx_q;
      out_q.last_out  <= s1_last_q;
    end
  end

  a_pend_needs_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> act_valid_q)
    else $error("pending line without an active one");

  a_no_job_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_i.valid |-> !pend_valid_q)
    else $error("line finished while pending slot is full");

  a_banks_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_valid_q && pend_valid_q && !act_reject_q && !pend_reject_q |->
      act_bank_q != pend_bank_q)
    else $error("active and pending lines share a bank");

  a_write_off_read_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_wr_i.en && act_valid_q && !act_reject_q |-> key_wr_i.bank != act_bank_q)
    else $error("key write into the bank being sent");

endmodule

/* hdl/ssh_ed25519_key_line_parser.sv */
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_ready_o   | in_data_i  (char_in, line_end)
// out     | output    | out_valid_o / out_ready_i | out_data_o (status, key_byte,
//         |           |                           |   key_index, last_out)
//
// one character per cycle while in_ready_o is high; a line end gives 32 key transfers or one reject,
//   read from the key store at one entry per cycle unless the output stalls
// the key store has two banks: a line decodes into one while the other drains
// in_ready_o drops only while one finished line waits behind another still
//   draining; a stalled output holds its transfer, the read pipe backs up
// reset is asynchronous and clears all control state, no clearing pass:
//   the key store is always fully written before it is read
module ssh_ed25519_key_line_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sshkp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sshkp_pkg::out_item_t out_data_o
);
  import sshkp_pkg::*;

  key_wr_t key_wr;   // decoded key byte into the store
  job_t    job;      // line end with its verdict and bank
  logic    job_ready;

  // text front end: blank skip, name match, base64 decode, blob header check
  sshkp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (job_ready),
    .in_data_i  (in_data_i),
    .key_wr_o   (key_wr),
    .job_o      (job)
  );

  // key store plus the result sequencer that drains it
  sshkp_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_wr_i    (key_wr),
    .job_i       (job),
    .job_ready_o (job_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // the front end keeps taking characters unless a finished line is queued
  assign in_ready_o = job_ready;

endmodule
